// File: sv/rc4_stream_cipher_defines.svh
// Assertion macros for the checker of the RC4 stream cipher.
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// Concurrent assertion on an explicit clock and synchronous reset.
`define RC4_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Concurrent assertion on the clk and rst signals of the enclosing module.
`define RC4_ASSERT(label, prop, msg) \
  `RC4_ASSERT_CLK(label, clk, rst, prop, msg)

`endif

// File: sv/rc4_pkg.sv
// Package with the constants and control types of the RC4 stream cipher.
package rc4_pkg;

  localparam int KEY_BYTES_MAX_DEF = 8;
  localparam int SBOX_DEPTH        = 256;
  localparam int SBOX_AW           = 8;
  localparam int CNT_W             = SBOX_AW + 1;
  localparam int KEY_W             = 64;
  localparam int KEY_LEN_W         = 4;

  localparam logic OP_CRYPT = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Commands from the controller to the datapath, one step each.
  typedef struct packed {
    logic capture;
    logic cnt_clr;
    logic cnt_inc;
    logic init_wr;
    logic ksa_j;
    logic ksa_wn;
    logic ksa_wj;
    logic copy;
    logic prga_a;
    logic prga_b;
    logic prga_c;
    logic prga_d;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic sweep_last;
    logic copy_done;
    logic out_free;
    logic end_flag;
  } status_t;

endpackage

// File: sv/rc4_in_if.sv
// Input channel interface: one data byte or one key load per transfer.
interface rc4_in_if;
  import rc4_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [7:0]           data_byte;
  logic                 message_end;
  logic [KEY_W-1:0]     key_bytes;
  logic [KEY_LEN_W-1:0] key_length;

  modport source (
    output valid, operation, data_byte, message_end, key_bytes, key_length,
    input  ready
  );
  modport sink (
    input  valid, operation, data_byte, message_end, key_bytes, key_length,
    output ready
  );
endinterface

// File: sv/rc4_out_if.sv
// Output channel interface: one crypted byte per transfer.
interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink (input valid, out_byte, output ready);
endinterface

// File: sv/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher with per-message keystream restart.
//
// The item channel carries either a key load (operation high) or one data
// byte (operation low). A key load runs the RC4 key schedule over 1 to
// KEY_BYTES_MAX key bytes into the base S-box and produces no result. A data
// byte is XORed with the next keystream byte and leaves on the result channel.
// A byte marked message_end is the last of its message: afterwards the working
// S-box is copied back from the base S-box and both indices return to zero.
// A data byte passes through the states PRGA_A, PRGA_B, PRGA_C and PRGA_D
// into the output register, and the next item can transfer only once the
// controller is back in idle. The working S-box has one read and one write
// port, and each byte needs two reads, two swap writes and a third read. The
// copy after a message end walks the whole S-box. A key load fills the base
// S-box, runs the schedule in KSA_RD, KSA_J, KSA_WN and KSA_WJ, then copies.
// Reset clears the controller, the indices and the result valid; the S-boxes
// hold nothing useful until the first key load, which must come first.
// If the receiver stalls, the finished byte waits in the output register; the
// block still takes the next item and holds the following result until the
// register is free.
module rc4_stream_cipher #(
  parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
  input logic clk,
  input logic rst,
  rc4_in_if.sink    item,
  rc4_out_if.source result
);
  import rc4_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller owns the handshake on the item side and steps the datapath.
  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_op    (item.operation),
    .in_ready (item.ready),
    .cmd      (cmd),
    .status   (status)
  );

  // The datapath holds both S-boxes and the output register.
  rc4_dp #(
    .KEY_BYTES_MAX (KEY_BYTES_MAX)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .data_byte   (item.data_byte),
    .message_end (item.message_end),
    .key_bytes   (item.key_bytes),
    .key_length  (item.key_length),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_byte    (result.out_byte)
  );

endmodule

// File: sv/rc4_ctrl.sv
// Controller state machine that sequences key schedule, keystream and copy steps.
module rc4_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_op,
  output logic            in_ready,
  output rc4_pkg::cmd_t   cmd,
  input  rc4_pkg::status_t status
);
  import rc4_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_KSA_RD = 4'd2;
  localparam logic [3:0] S_KSA_J  = 4'd3;
  localparam logic [3:0] S_KSA_WN = 4'd4;
  localparam logic [3:0] S_KSA_WJ = 4'd5;
  localparam logic [3:0] S_COPY   = 4'd6;
  localparam logic [3:0] S_PRGA_A = 4'd7;
  localparam logic [3:0] S_PRGA_B = 4'd8;
  localparam logic [3:0] S_PRGA_C = 4'd9;
  localparam logic [3:0] S_PRGA_D = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_next  = (in_op == OP_LOAD) ? S_INIT : S_PRGA_A;
        end
      end
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (status.sweep_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_KSA_RD;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_KSA_RD: begin
        state_next = S_KSA_J;
      end
      S_KSA_J: begin
        cmd.ksa_j  = 1'b1;
        state_next = S_KSA_WN;
      end
      S_KSA_WN: begin
        cmd.ksa_wn = 1'b1;
        state_next = S_KSA_WJ;
      end
      S_KSA_WJ: begin
        cmd.ksa_wj = 1'b1;
        if (status.sweep_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_COPY;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = S_KSA_RD;
        end
      end
      S_COPY: begin
        cmd.copy    = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (status.copy_done) begin
          state_next = S_IDLE;
        end
      end
      S_PRGA_A: begin
        cmd.prga_a = 1'b1;
        state_next = S_PRGA_B;
      end
      S_PRGA_B: begin
        cmd.prga_b = 1'b1;
        state_next = S_PRGA_C;
      end
      S_PRGA_C: begin
        cmd.prga_c = 1'b1;
        state_next = S_PRGA_D;
      end
      S_PRGA_D: begin
        cmd.prga_d = 1'b1;
        // Hold here until the output register can take the byte.
        if (status.out_free) begin
          if (status.end_flag) begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_COPY;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/rc4_dp.sv
// Datapath with the base and working S-box memories, indices and output register.
module rc4_dp #(
  parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rc4_pkg::cmd_t                 cmd,
  output rc4_pkg::status_t              status,
  input  logic [7:0]                    data_byte,
  input  logic                          message_end,
  input  logic [rc4_pkg::KEY_W-1:0]     key_bytes,
  input  logic [rc4_pkg::KEY_LEN_W-1:0] key_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte
);
  import rc4_pkg::*;

  localparam int KPW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;

  logic [7:0] base_mem [SBOX_DEPTH];
  logic [7:0] work_mem [SBOX_DEPTH];

  logic [SBOX_AW-1:0] base_raddr, base_waddr, work_raddr, work_waddr;
  logic [7:0]         base_rdata, base_wdata, work_rdata, work_wdata;
  logic               base_we, work_we;

  logic [7:0]                 data_r;
  logic                       end_r;
  logic [8*KEY_BYTES_MAX-1:0] key_r;
  logic [KEY_LEN_W-1:0]       len_r;
  logic [KEY_LEN_W-1:0]       len_c;
  logic [KPW-1:0]             kpos;
  logic [KEY_LEN_W-1:0]       kpos_inc;
  logic [CNT_W-1:0]           cnt;
  logic [7:0]                 kj, kj_next, kb;
  logic [7:0]                 idx_i, idx_j;
  logic [7:0]                 i_inc, j_new, t_sum, t_r;
  logic [7:0]                 s_n, s_j, s_t;
  logic                       byp_i, byp_j;
  logic                       out_free;

  always_ff @(posedge clk) begin
    if (base_we) begin
      base_mem[base_waddr] <= base_wdata;
    end
    base_rdata <= base_mem[base_raddr];
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_rdata <= work_mem[work_raddr];
  end

  always_comb begin
    if (key_length == '0) begin
      len_c = KEY_LEN_W'(1);
    end else if (key_length > KEY_LEN_W'(KEY_BYTES_MAX)) begin
      len_c = KEY_LEN_W'(KEY_BYTES_MAX);
    end else begin
      len_c = key_length;
    end
  end

  assign kb       = key_r[8*kpos +: 8];
  assign kpos_inc = KEY_LEN_W'(kpos) + KEY_LEN_W'(1);
  assign kj_next  = kj + base_rdata + kb;
  assign i_inc    = idx_i + 8'd1;
  assign j_new    = idx_j + work_rdata;
  assign t_sum    = s_n + work_rdata;
  assign out_free = !out_valid || out_ready;

  // The t read overlaps the swap writes, so recent writes are forwarded.
  assign s_t = byp_j ? s_n : (byp_i ? s_j : work_rdata);

  always_comb begin
    base_raddr = cmd.ksa_j ? kj_next : cnt[SBOX_AW-1:0];
    base_we    = cmd.init_wr || cmd.ksa_wn || cmd.ksa_wj;
    base_waddr = cmd.ksa_wj ? kj : cnt[SBOX_AW-1:0];
    if (cmd.init_wr) begin
      base_wdata = cnt[SBOX_AW-1:0];
    end else if (cmd.ksa_wn) begin
      base_wdata = base_rdata;
    end else begin
      base_wdata = s_n;
    end
  end

  always_comb begin
    if (cmd.prga_a) begin
      work_raddr = i_inc;
    end else if (cmd.prga_b) begin
      work_raddr = j_new;
    end else if (cmd.prga_c) begin
      work_raddr = t_sum;
    end else begin
      work_raddr = t_r;
    end
    work_we = cmd.prga_c || cmd.prga_d || (cmd.copy && (cnt != '0));
    if (cmd.prga_c) begin
      work_waddr = idx_i;
      work_wdata = work_rdata;
    end else if (cmd.prga_d) begin
      work_waddr = idx_j;
      work_wdata = s_n;
    end else begin
      work_waddr = cnt[SBOX_AW-1:0] - SBOX_AW'(1);
      work_wdata = base_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      data_r <= data_byte;
      end_r  <= message_end;
      key_r  <= key_bytes[8*KEY_BYTES_MAX-1:0];
      len_r  <= len_c;
      kj     <= '0;
      kpos   <= '0;
    end
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.ksa_j) begin
      kj  <= kj_next;
      s_n <= base_rdata;
    end
    if (cmd.ksa_wj) begin
      kpos <= (kpos_inc == len_r) ? '0 : KPW'(kpos_inc);
    end
    if (cmd.prga_b) begin
      s_n <= work_rdata;
    end
    if (cmd.prga_c) begin
      s_j   <= work_rdata;
      t_r   <= t_sum;
      byp_i <= (t_sum == idx_i);
      byp_j <= (t_sum == idx_j);
    end
    if (cmd.prga_d && out_free) begin
      out_byte <= data_r ^ s_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i     <= '0;
      idx_j     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.copy) begin
        idx_i <= '0;
        idx_j <= '0;
      end
      if (cmd.prga_a) begin
        idx_i <= i_inc;
      end
      if (cmd.prga_b) begin
        idx_j <= j_new;
      end
      if (cmd.prga_d && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.sweep_last = (cnt[SBOX_AW-1:0] == '1);
  assign status.copy_done  = cnt[CNT_W-1];
  assign status.out_free   = out_free;
  assign status.end_flag   = end_r;

endmodule

// File: sv/rc4_checker.sv
// Port-level checker for the RC4 stream cipher and its bind statement.
`include "rc4_stream_cipher_defines.svh"

module rc4_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte
);

  // A stalled result keeps its byte.
  `RC4_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte), "result changed while stalled")

  // One item at a time: after a transfer the item side closes.
  `RC4_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "item taken while busy")

  // An item transfer is not directly followed by a rising result.
  `RC4_ASSERT(a_min_latency, in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid), "result too early")

  // A new result is produced only while the item side is closed.
  `RC4_ASSERT(a_rise_busy, $rose(out_valid) |-> !$past(in_ready), "result rose while idle")

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_byte  (result.out_byte)
);

// File: tb/rc4_stream_cipher_tb.sv
// Self-checking testbench for the RC4 stream cipher with per-message keystream restart.
`timescale 1ns / 1ps

module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  // One pending item for the driver. When hold_for_drain is set, the driver
  // keeps it back until every crypted byte already owed has come out.
  typedef struct {
    logic                 op;
    logic [7:0]           data;
    logic                 last;
    logic [KEY_W-1:0]     key;
    logic [KEY_LEN_W-1:0] key_len;
    bit                   hold_for_drain;
  } cipher_req_t;

  localparam int TARGET_ITEMS   = 600;
  localparam int IDLE_PERCENT   = 28;
  localparam int MAX_REPORTS    = 10;
  // A key load is the longest thing the block does without producing a result,
  // so the tail waits a little longer than a key load takes.
  localparam int TAIL_CYCLES    = 1600;
  // Items accepted in this range are sent with no idling on either side.
  localparam int QUIET_FIRST    = 200;
  localparam int QUIET_LAST     = 330;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rc4_in_if  item_ch ();
  rc4_out_if result_ch ();

  rc4_stream_cipher u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always #1 clk = ~clk;

  cipher_req_t request_q[$];
  logic [7:0]  crypted_bytes_q[$];

  // Keystream state of the predictor: keyed S-box, working S-box, indices.
  logic [7:0] ks_base [SBOX_DEPTH];
  logic [7:0] ks_work [SBOX_DEPTH];
  logic [7:0] ks_i;
  logic [7:0] ks_j;

  int  items_total;
  int  items_accepted;
  int  keys_loaded;
  int  bytes_crypted;
  int  messages_closed;
  int  results_checked;
  int  failures;
  bit  in_taken;
  bit  quiet;
  bit  [15:0] key_lengths_seen;

  assign quiet = (items_accepted >= QUIET_FIRST) && (items_accepted < QUIET_LAST);

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Every message starts again from the keyed S-box with both indices at zero.
  task automatic rc4_restart();
    ks_work = ks_base;
    ks_i    = 8'd0;
    ks_j    = 8'd0;
  endtask

  // Standard key schedule. A length of zero counts as one byte, and lengths
  // above the key register size are clipped to it.
  task automatic rc4_load_key(input logic [KEY_W-1:0] key,
                              input logic [KEY_LEN_W-1:0] key_len);
    int unsigned len;
    logic [7:0]  j;
    logic [7:0]  kb;
    logic [7:0]  swap_tmp;
    len = 32'(key_len);
    if (len == 0) len = 1;
    if (len > KEY_BYTES_MAX_DEF) len = KEY_BYTES_MAX_DEF;
    for (int n = 0; n < SBOX_DEPTH; n++) ks_base[n] = n[7:0];
    j = 8'd0;
    for (int n = 0; n < SBOX_DEPTH; n++) begin
      kb         = key[8 * (n % len) +: 8];
      j          = j + ks_base[n] + kb;
      swap_tmp   = ks_base[n];
      ks_base[n] = ks_base[j];
      ks_base[j] = swap_tmp;
    end
    rc4_restart();
  endtask

  // One step of the keystream generator on the working S-box.
  task automatic keystream_xor(input logic [7:0] data_in, input logic last,
                               output logic [7:0] crypted);
    logic [7:0] swap_tmp;
    logic [7:0] t;
    ks_i          = ks_i + 8'd1;
    ks_j          = ks_j + ks_work[ks_i];
    swap_tmp      = ks_work[ks_i];
    ks_work[ks_i] = ks_work[ks_j];
    ks_work[ks_j] = swap_tmp;
    t             = ks_work[ks_i] + ks_work[ks_j];
    crypted       = data_in ^ ks_work[t];
    if (last) rc4_restart();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Fields that the operation ignores get random values so
  // that the block is seen to really ignore them.
  // ---------------------------------------------------------------------------

  task automatic push_load(input logic [KEY_W-1:0] key,
                           input logic [KEY_LEN_W-1:0] key_len, input bit drain);
    cipher_req_t req;
    req.op             = OP_LOAD;
    req.data           = 8'($urandom_range(255));
    req.last           = 1'($urandom_range(1));
    req.key            = key;
    req.key_len        = key_len;
    req.hold_for_drain = drain;
    request_q.push_back(req);
  endtask

  task automatic push_data(input logic [7:0] data, input logic last, input bit drain);
    cipher_req_t req;
    req.op             = OP_CRYPT;
    req.data           = data;
    req.last           = last;
    req.key            = {$urandom, $urandom};
    req.key_len        = KEY_LEN_W'($urandom_range(15));
    req.hold_for_drain = drain;
    request_q.push_back(req);
  endtask

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("%0t ns: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the next pending item at the falling edge once the
  // previous one has made its transfer, and idles at random in between.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_items
    cipher_req_t req;
    bit          idle;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || in_taken) begin
      idle = !quiet && ($urandom_range(99) < IDLE_PERCENT);
      if (request_q.size() == 0 || idle ||
          (request_q[0].hold_for_drain && crypted_bytes_q.size() != 0)) begin
        item_ch.valid <= 1'b0;
      end else begin
        req = request_q.pop_front();
        item_ch.valid       <= 1'b1;
        item_ch.operation   <= req.op;
        item_ch.data_byte   <= req.data;
        item_ch.message_end <= req.last;
        item_ch.key_bytes   <= req.key;
        item_ch.key_length  <= req.key_len;
      end
    end
  end

  // The receiver stalls at random, except during the quiet stretch.
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, checks each result transfer against the
  // oldest predicted byte, then feeds each accepted item to the predictor.
  // The result is handled first so that a new expectation can never be
  // matched against a result from the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    logic [7:0] want;
    logic [7:0] crypted;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= item_ch.valid && item_ch.ready;

      if (result_ch.valid && result_ch.ready) begin
        if (crypted_bytes_q.size() == 0) begin
          note_failure($sformatf("unexpected result transfer, out_byte 0x%02h",
                                 result_ch.out_byte));
        end else begin
          want = crypted_bytes_q.pop_front();
          results_checked++;
          if (result_ch.out_byte !== want)
            note_failure($sformatf("out_byte mismatch: expected 0x%02h, got 0x%02h",
                                   want, result_ch.out_byte));
        end
      end

      if (item_ch.valid && item_ch.ready) begin
        items_accepted++;
        if (item_ch.operation == OP_LOAD) begin
          rc4_load_key(item_ch.key_bytes, item_ch.key_length);
          keys_loaded++;
          key_lengths_seen[item_ch.key_length] = 1'b1;
        end else begin
          keystream_xor(item_ch.data_byte, item_ch.message_end, crypted);
          crypted_bytes_q.push_back(crypted);
          bytes_crypted++;
          if (item_ch.message_end) messages_closed++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: build the stimulus, reset, wait for everything to drain.
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    int          klen;
    int          msg_len;
    bit          broken;
    logic [KEY_W-1:0] default_key;

    item_ch.valid       = 1'b0;
    item_ch.operation   = OP_CRYPT;
    item_ch.data_byte   = 8'h00;
    item_ch.message_end = 1'b0;
    item_ch.key_bytes   = '0;
    item_ch.key_length  = '0;
    result_ch.ready     = 1'b0;

    // The default key is the ASCII text "12345678", first character in byte 0.
    default_key = 64'h3837_3635_3433_3231;

    // Directed part. A key always comes first, since data before any key is
    // not allowed. Extreme data bytes, a message end with its restart, and a
    // one-byte message that must repeat the first keystream byte.
    push_load(default_key, 4'd8, 1'b0);
    push_data(8'h00, 1'b0, 1'b0);
    push_data(8'hFF, 1'b0, 1'b0);
    push_data(8'hA5, 1'b0, 1'b0);
    push_data(8'h5A, 1'b1, 1'b0);
    push_data(8'h00, 1'b1, 1'b1);
    // A key length of zero behaves as a single key byte.
    push_load({KEY_W{1'b1}}, 4'd0, 1'b0);
    push_data(8'hFF, 1'b1, 1'b0);
    // Lengths above the key size saturate to the full eight bytes.
    push_load({KEY_W{1'b0}}, 4'd15, 1'b0);
    push_data(8'h80, 1'b0, 1'b0);
    push_data(8'h01, 1'b1, 1'b0);
    push_load(64'h0123_4567_89AB_CDEF, 4'd9, 1'b0);
    push_data(8'h7F, 1'b0, 1'b0);
    // A key load in mid-message abandons the message in progress.
    push_load(64'h0000_0000_0000_0001, 4'd1, 1'b0);
    push_data(8'h34, 1'b1, 1'b0);
    // The sender pauses here until every owed result has come out.
    push_load(64'hFEDC_BA98_7654_3210, 4'd8, 1'b1);
    push_data(8'h00, 1'b0, 1'b0);
    push_data(8'hFF, 1'b0, 1'b0);
    push_data(8'h55, 1'b1, 1'b0);
    push_load(default_key, 4'd2, 1'b0);
    push_data(8'hC3, 1'b1, 1'b0);

    // Random part: mostly well-formed messages under a random key, with some
    // messages left open so that a later key load or message runs into them.
    while (request_q.size() < TARGET_ITEMS) begin
      if ($urandom_range(99) < 15) begin
        klen = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
        push_load({$urandom, $urandom}, klen[KEY_LEN_W-1:0], $urandom_range(19) == 0);
      end else begin
        msg_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        broken  = ($urandom_range(99) < 12);
        for (int k = 0; k < msg_len; k++)
          push_data(8'($urandom_range(255)), (k == msg_len - 1) && !broken,
                    (k == 0) && ($urandom_range(29) == 0));
      end
    end
    items_total = request_q.size();

    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (items_accepted == items_total);
    wait (crypted_bytes_q.size() == 0);
    // Stray results would show up in this window.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run summary: %0d items, %0d key loads (%0d distinct length codes),",
             items_total, keys_loaded, $countones(key_lengths_seen));
    $display("  %0d bytes crypted in %0d closed messages, %0d results checked, %0d failures",
             bytes_crypted, messages_closed, results_checked, failures);
    if (failures == 0) begin
      $display("[rc4_stream_cipher] OK");
    end else begin
      $display("[rc4_stream_cipher] ERROR");
    end
    $finish;
  end

  // Watchdog: the expected run is well under a tenth of this.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout: %0d of %0d items transferred, %0d results outstanding",
             items_accepted, items_total, crypted_bytes_q.size());
    $display("[rc4_stream_cipher] ERROR");
    $finish;
  end

endmodule
